// ===== design/sicrs_pkg.sv =====
// ----------------------------------------------------------------------------
// sicrs_pkg
// Shared widths, comparison kind codes and item types for the set-id column
// range search block.
// ----------------------------------------------------------------------------
package sicrs_pkg;

   localparam int ROWS_DEFAULT = 1024;

   localparam int IDX_W  = 10;   // load row field
   localparam int VAL_W  = 10;   // stored set identifier
   localparam int KEY_W  = 32;   // query key
   localparam int KIND_W = 3;    // comparison kind
   localparam int POS_W  = 11;   // row positions and range bounds

   localparam logic             OP_LOAD  = 1'b0;
   localparam logic             OP_QUERY = 1'b1;

   localparam logic [KIND_W-1:0] KIND_EQ       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NE       = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LT       = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LE       = 3'd3;
   localparam logic [KIND_W-1:0] KIND_GT       = 3'd4;
   localparam logic [KIND_W-1:0] KIND_GE       = 3'd5;
   localparam logic [KIND_W-1:0] KIND_NOT_NULL = 3'd6;
   localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd7;

   typedef struct packed {
      logic [KIND_W-1:0] compare_kind;
      logic [KEY_W-1:0]  key_value;
      logic [POS_W-1:0]  range_lo;
      logic [POS_W-1:0]  range_hi;
   } query_type;

   typedef struct packed {
      logic [POS_W-1:0] result_lo;
      logic [POS_W-1:0] result_hi;
      logic             complement;
   } result_type;

endpackage

// ===== design/sicrs_column_mem.sv =====
// ----------------------------------------------------------------------------
// sicrs_column_mem
// Column store of set identifiers: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module sicrs_column_mem
   import sicrs_pkg::*;
#(
   parameter int ROWS = ROWS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(ROWS)-1:0]  wr_addr,
   input  logic [VAL_W-1:0]         wr_data,
   input  logic [$clog2(ROWS)-1:0]  rd_addr,
   output logic [VAL_W-1:0]         rd_data
);

   logic [VAL_W-1:0] mem [ROWS];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sicrs_search_ctrl.sv =====
// ----------------------------------------------------------------------------
// sicrs_search_ctrl
// Query sequencer: set-id shortcut checks for the lower bound, then a halving
// search for the upper bound, one column read per cycle.
// ----------------------------------------------------------------------------
module sicrs_search_ctrl
   import sicrs_pkg::*;
#(
   parameter int ROWS = ROWS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  query_type                query,
   input  logic                     out_free,
   input  logic [VAL_W-1:0]         rd_data,
   output logic [$clog2(ROWS)-1:0]  rd_addr,
   output logic                     idle,
   output logic                     res_valid,
   output result_type               res
);

   localparam int AW = $clog2(ROWS);
   localparam logic [KEY_W-1:0] ROWS_U   = KEY_W'(ROWS);
   localparam logic [POS_W-1:0] ROWS_POS = POS_W'(ROWS);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_LB_LO   = 7'b0000010,
      S_LB_KEY  = 7'b0000100,
      S_LB_KCHK = 7'b0001000,
      S_UB_INIT = 7'b0010000,
      S_UB_STEP = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   function automatic logic need_lb_f(input logic [KIND_W-1:0] kind);
      logic r;
      case (kind) inside
         KIND_EQ, KIND_NE, KIND_LT, KIND_GE: r = 1'b1;
         default:                            r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic need_ub_f(input logic [KIND_W-1:0] kind);
      logic r;
      case (kind) inside
         KIND_EQ, KIND_NE, KIND_LE, KIND_GT: r = 1'b1;
         default:                            r = 1'b0;
      endcase
      return r;
   endfunction

   state_type         state_ff, state_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [POS_W-1:0]  lo_ff, lo_in;
   logic [POS_W-1:0]  hi_ff, hi_in;
   logic              empty_ff, empty_in;
   logic              lb_pend_ff, lb_pend_in;
   logic [POS_W-1:0]  lb_ff, lb_in;
   logic [POS_W-1:0]  ub_ff, ub_in;
   logic [POS_W-1:0]  first_ff, first_in;
   logic [POS_W-1:0]  count_ff, count_in;
   logic [POS_W-1:0]  step_ff, step_in;
   logic [POS_W-1:0]  mid_ff, mid_in;

   logic [POS_W-1:0]  lo_sat, hi_sat;
   logic              key_in_range, key_hit;
   logic [POS_W-1:0]  init_first, init_count, init_step;
   logic [POS_W-1:0]  nxt_first, nxt_count;
   logic [POS_W-1:0]  rd_pos;

   assign lo_sat = (KEY_W'(query.range_lo) > ROWS_U) ? ROWS_POS : query.range_lo;
   assign hi_sat = (KEY_W'(query.range_hi) > ROWS_U) ? ROWS_POS : query.range_hi;

   assign key_hit      = (KEY_W'(rd_data) == key_ff);
   assign key_in_range = (key_ff >= KEY_W'(lo_ff)) && (key_ff < KEY_W'(hi_ff));

   // The search window starts at the larger of the key and range_lo. Only
   // used when the key is below range_hi, so the key fits a row position.
   assign init_first = (key_ff > KEY_W'(lo_ff)) ? key_ff[POS_W-1:0] : lo_ff;
   assign init_count = hi_ff - init_first;
   assign init_step  = init_count >> 1;

   always_comb begin
      if (KEY_W'(rd_data) > key_ff) begin
         nxt_first = first_ff;
         nxt_count = step_ff;
      end else begin
         nxt_first = mid_ff + POS_W'(1);
         nxt_count = count_ff - step_ff - POS_W'(1);
      end
   end

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      key_in     = key_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      empty_in   = empty_ff;
      lb_pend_in = lb_pend_ff;
      lb_in      = lb_ff;
      ub_in      = ub_ff;
      first_in   = first_ff;
      count_in   = count_ff;
      step_in    = step_ff;
      mid_in     = mid_ff;
      rd_pos     = lo_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in    = query.compare_kind;
               key_in     = query.key_value;
               lo_in      = lo_sat;
               hi_in      = hi_sat;
               empty_in   = (lo_sat >= hi_sat);
               lb_pend_in = 1'b0;
               if ((lo_sat >= hi_sat) ||
                   !(need_lb_f(query.compare_kind) || need_ub_f(query.compare_kind))) begin
                  state_in = S_DONE;
               end else if (need_lb_f(query.compare_kind)) begin
                  state_in = S_LB_LO;
               end else begin
                  state_in = S_UB_INIT;
               end
            end
         end
         S_LB_LO: begin
            rd_pos   = lo_ff;
            state_in = S_LB_KEY;
         end
         S_LB_KEY: begin
            rd_pos = key_ff[POS_W-1:0];
            if (key_hit) begin
               lb_in    = lo_ff;
               state_in = need_ub_f(kind_ff) ? S_UB_INIT : S_DONE;
            end else if (key_in_range) begin
               state_in = S_LB_KCHK;
            end else begin
               lb_pend_in = 1'b1;
               state_in   = S_UB_INIT;
            end
         end
         S_LB_KCHK: begin
            if (key_hit) begin
               lb_in    = key_ff[POS_W-1:0];
               state_in = need_ub_f(kind_ff) ? S_UB_INIT : S_DONE;
            end else begin
               lb_pend_in = 1'b1;
               state_in   = S_UB_INIT;
            end
         end
         S_UB_INIT: begin
            rd_pos = init_first + init_step;
            if (key_ff >= KEY_W'(hi_ff)) begin
               ub_in    = hi_ff;
               if (lb_pend_ff) begin
                  lb_in = hi_ff;
               end
               state_in = S_DONE;
            end else begin
               first_in = init_first;
               count_in = init_count;
               step_in  = init_step;
               mid_in   = init_first + init_step;
               state_in = S_UB_STEP;
            end
         end
         S_UB_STEP: begin
            rd_pos = nxt_first + (nxt_count >> 1);
            if (nxt_count == '0) begin
               ub_in = nxt_first;
               if (lb_pend_ff) begin
                  lb_in = nxt_first;
               end
               state_in = S_DONE;
            end else begin
               first_in = nxt_first;
               count_in = nxt_count;
               step_in  = nxt_count >> 1;
               mid_in   = nxt_first + (nxt_count >> 1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         lb_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         lb_pend_ff <= lb_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      key_ff   <= key_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      empty_ff <= empty_in;
      lb_ff    <= lb_in;
      ub_ff    <= ub_in;
      first_ff <= first_in;
      count_ff <= count_in;
      step_ff  <= step_in;
      mid_ff   <= mid_in;
   end

   // Read positions are cut to the address width; only reads of rows below range_hi are used.
   assign rd_addr = AW'(rd_pos);

   always_comb begin
      res = '0;
      if (!empty_ff) begin
         case (kind_ff)
            KIND_EQ:       res = '{result_lo: lb_ff, result_hi: ub_ff, complement: 1'b0};
            KIND_NE:       res = '{result_lo: lb_ff, result_hi: ub_ff, complement: 1'b1};
            KIND_LT:       res = '{result_lo: lo_ff, result_hi: lb_ff, complement: 1'b0};
            KIND_LE:       res = '{result_lo: lo_ff, result_hi: ub_ff, complement: 1'b0};
            KIND_GT:       res = '{result_lo: ub_ff, result_hi: hi_ff, complement: 1'b0};
            KIND_GE:       res = '{result_lo: lb_ff, result_hi: hi_ff, complement: 1'b0};
            KIND_NOT_NULL: res = '{result_lo: lo_ff, result_hi: hi_ff, complement: 1'b0};
            default:       res = '0;
         endcase
      end
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE) && out_free;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == S_IDLE)
      else $error("query started while a search is in progress");

   a_step_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UB_STEP |-> count_ff != '0)
      else $error("search step entered with an empty window");

   a_window_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UB_STEP |->
         (POS_W+1)'(first_ff) + (POS_W+1)'(count_ff) <= (POS_W+1)'(hi_ff))
      else $error("search window extends past range_hi");

   a_result_ordered: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> res.result_lo <= res.result_hi)
      else $error("result range is inverted");

endmodule

// ===== design/set_id_column_range_search_top.sv =====
// ----------------------------------------------------------------------------
// set_id_column_range_search_top
// Sorted set-id column with range queries answered by shortcut checks and a
// halving search over the column memory.
// ----------------------------------------------------------------------------
// A load item (op 0) writes one column row in the cycle it is accepted and
// the block stays ready. A query item (op 1) is worked on alone: capture,
// the lower-bound shortcut reads of the range's first row and of the key's
// row where the kind needs them, opening of the search window, about
// log2(range) + 1 halving steps (11 for 1024 rows), then hand-over of the
// result, which waits while the output register is full. The single read
// port of the column memory, with its registered read data, paces each
// dependent search step. Not-null, empty kinds and empty ranges go from
// capture straight to hand-over. The result waits in an output register,
// so the next item is accepted while it is not yet taken. The column has
// no reset; rows must be loaded before a query reads them.
// ----------------------------------------------------------------------------
module set_id_column_range_search_top
   import sicrs_pkg::*;
#(
   parameter int ROWS = ROWS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [IDX_W-1:0]  req_entry_index,
   input  logic [VAL_W-1:0]  req_entry_value,
   input  logic [KIND_W-1:0] req_compare_kind,
   input  logic [KEY_W-1:0]  req_key_value,
   input  logic [POS_W-1:0]  req_range_lo,
   input  logic [POS_W-1:0]  req_range_hi,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [POS_W-1:0]  rsp_result_lo,
   output logic [POS_W-1:0]  rsp_result_hi,
   output logic              rsp_complement
);

   localparam int AW = $clog2(ROWS);
   localparam logic [KEY_W-1:0] ROWS_U = KEY_W'(ROWS);

   logic             accept;
   logic             wr_en;
   logic             start;
   logic             idle;
   logic             out_free;
   logic             res_valid;
   result_type       res;
   query_type        query;
   logic [AW-1:0]    rd_addr;
   logic [VAL_W-1:0] rd_data;

   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, rsp_in;

   // No item is taken while reset is held, so none can be lost to it.
   assign req_ready = idle && !reset;
   assign accept    = req_valid && req_ready;
   assign start     = accept && (req_op == OP_QUERY);
   // Loads past the end of the column are dropped.
   assign wr_en     = accept && (req_op == OP_LOAD) && (KEY_W'(req_entry_index) < ROWS_U);

   assign query = '{compare_kind: req_compare_kind, key_value: req_key_value,
                    range_lo: req_range_lo, range_hi: req_range_hi};

   assign out_free = !rsp_valid_ff || rsp_ready;

   sicrs_column_mem #(.ROWS(ROWS)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (req_entry_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A load writes at its accept edge and the next query reads no earlier
   // than the following edge, so reads always see completed writes.
   sicrs_search_ctrl #(.ROWS(ROWS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .query     (query),
      .out_free  (out_free),
      .rd_data   (rd_data),
      .rd_addr   (rd_addr),
      .idle      (idle),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result_lo  = rsp_ff.result_lo;
   assign rsp_result_hi  = rsp_ff.result_hi;
   assign rsp_complement = rsp_ff.complement;

endmodule

// ===== verif/set_id_column_range_search_top_tb.sv =====
// ----------------------------------------------------------------------------
// set_id_column_range_search_top_tb
// Loads a sorted set-id column, then sends directed and random range queries
// mixed with column rewrites, and checks every result against a predictor
// that keeps its own copy of the column.
// ----------------------------------------------------------------------------
module set_id_column_range_search_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sicrs_pkg::*;

   localparam int ROWS         = ROWS_DEFAULT;
   localparam int RANDOM_ITEMS = 750;
   localparam int DRAIN_CYCLES = 32;
   localparam logic [POS_W-1:0] ROWS_POS = POS_W'(ROWS);

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_op           = OP_LOAD;
   logic [IDX_W-1:0]  req_entry_index  = '0;
   logic [VAL_W-1:0]  req_entry_value  = '0;
   logic [KIND_W-1:0] req_compare_kind = KIND_EQ;
   logic [KEY_W-1:0]  req_key_value    = '0;
   logic [POS_W-1:0]  req_range_lo     = '0;
   logic [POS_W-1:0]  req_range_hi     = '0;
   logic              rsp_ready        = 1'b0;
   logic              req_ready;
   logic              rsp_valid;
   logic [POS_W-1:0]  rsp_result_lo;
   logic [POS_W-1:0]  rsp_result_hi;
   logic              rsp_complement;

   logic [VAL_W-1:0] column_model [ROWS];
   result_type       expected_results [$];
   result_type       expected_next;
   int               error_count = 0;
   int               item_count  = 0;
   bit               no_idle     = 1'b0;
   int               stall_count = 0;
   int               next_stall;

   set_id_column_range_search_top #(.ROWS(ROWS)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .req_compare_kind (req_compare_kind),
      .req_key_value    (req_key_value),
      .req_range_lo     (req_range_lo),
      .req_range_hi     (req_range_hi),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_lo    (rsp_result_lo),
      .rsp_result_hi    (rsp_result_hi),
      .rsp_complement   (rsp_complement)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // First row at or after max(lo, key) whose set id exceeds the key, or hi if none.
   function automatic int unsigned upper_row(logic [KEY_W-1:0] key, int unsigned lo,
                                             int unsigned hi);
      int unsigned first;
      int unsigned count;
      int unsigned half;
      int unsigned mid;
      if (key >= hi) return hi;
      first = (key > lo) ? key : lo;
      count = hi - first;
      while (count > 0) begin
         half = count / 2;
         mid  = first + half;
         if (KEY_W'(column_model[mid]) <= key) begin
            first = mid + 1;
            count = count - half - 1;
         end else begin
            count = half;
         end
      end
      return first;
   endfunction

   function automatic int unsigned lower_row(logic [KEY_W-1:0] key, int unsigned lo,
                                             int unsigned hi);
      if (KEY_W'(column_model[lo]) == key) return lo;
      // A set loaded by load_sets starts at the row whose index equals its id.
      if (key >= lo && key < hi && KEY_W'(column_model[key[IDX_W-1:0]]) == key) return key;
      return upper_row(key, lo, hi);
   endfunction

   function automatic result_type predict_range(logic [KIND_W-1:0] kind,
                                                logic [KEY_W-1:0] key,
                                                int unsigned lo_in, int unsigned hi_in);
      result_type  r;
      int unsigned lo;
      int unsigned hi;
      lo = (lo_in > ROWS) ? ROWS : lo_in;
      hi = (hi_in > ROWS) ? ROWS : hi_in;
      r  = '0;
      if (lo < hi) begin
         case (kind)
            KIND_EQ: begin
               r.result_lo = POS_W'(lower_row(key, lo, hi));
               r.result_hi = POS_W'(upper_row(key, lo, hi));
            end
            KIND_NE: begin
               r.result_lo  = POS_W'(lower_row(key, lo, hi));
               r.result_hi  = POS_W'(upper_row(key, lo, hi));
               r.complement = 1'b1;
            end
            KIND_LT: begin
               r.result_lo = POS_W'(lo);
               r.result_hi = POS_W'(lower_row(key, lo, hi));
            end
            KIND_LE: begin
               r.result_lo = POS_W'(lo);
               r.result_hi = POS_W'(upper_row(key, lo, hi));
            end
            KIND_GT: begin
               r.result_lo = POS_W'(upper_row(key, lo, hi));
               r.result_hi = POS_W'(hi);
            end
            KIND_GE: begin
               r.result_lo = POS_W'(lower_row(key, lo, hi));
               r.result_hi = POS_W'(hi);
            end
            KIND_NOT_NULL: begin
               r.result_lo = POS_W'(lo);
               r.result_hi = POS_W'(hi);
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   // Called at a rising edge; returns at the edge where the item is accepted,
   // with valid still high so that a back-to-back item needs no second update.
   task automatic send_item(logic op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
                            logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                            logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_entry_index  <= idx;
      req_entry_value  <= val;
      req_compare_kind <= kind;
      req_key_value    <= key;
      req_range_lo     <= lo;
      req_range_hi     <= hi;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (op == OP_LOAD) column_model[idx] = val;
      else expected_results.push_back(predict_range(kind, key, 32'(lo), 32'(hi)));
      item_count++;
   endtask

   // Query fields of a load item carry junk, and the other way round.
   task automatic send_load(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
      send_item(OP_LOAD, idx, val, KIND_W'($urandom_range(0, 7)), $urandom,
                POS_W'($urandom_range(0, ROWS)), POS_W'($urandom_range(0, ROWS)));
   endtask

   task automatic send_query(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                             logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
      send_item(OP_QUERY, IDX_W'($urandom_range(0, ROWS - 1)),
                VAL_W'($urandom_range(0, ROWS - 1)), kind, key, lo, hi);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // Writes rows [first, last) as a run of well-formed sets, the first one
   // starting at row first.
   task automatic load_sets(int first, int last);
      int set_id;
      int left;
      set_id = first;
      left   = 0;
      for (int row = first; row < last; row++) begin
         if (left == 0) begin
            set_id = row;
            left   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 120)
                                                 : $urandom_range(1, 8);
         end
         send_load(IDX_W'(row), VAL_W'(set_id));
         left--;
      end
   endtask

   task automatic random_query();
      int unsigned      lo;
      int unsigned      hi;
      int unsigned      row;
      int unsigned      sel;
      logic [KEY_W-1:0] key;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         lo = $urandom_range(0, ROWS);
         hi = $urandom_range(0, lo);
      end else if (sel == 1) begin
         lo = 0;
         hi = ROWS;
      end else begin
         lo = $urandom_range(0, ROWS - 1);
         hi = $urandom_range(lo + 1, ROWS);
      end
      row = (lo < hi) ? $urandom_range(lo, hi - 1) : $urandom_range(0, ROWS - 1);
      sel = $urandom_range(0, 19);
      if (sel < 8)       key = KEY_W'(column_model[row]);
      else if (sel < 12) key = row;
      else if (sel < 15) key = 32'(row) + 32'($urandom_range(0, 2)) - 32'd1;
      else if (sel < 17) key = $urandom_range(0, 1100);
      else               key = $urandom;
      send_query(KIND_W'($urandom_range(0, 7)), key, POS_W'(lo), POS_W'(hi));
   endtask

   task automatic test_column_fill();
      load_sets(0, ROWS);
   endtask

   task automatic test_directed_queries();
      int               start;
      logic [KEY_W-1:0] mid_key;
      // The last row opens a set of its own, which puts the top id in the column.
      send_load(IDX_W'(ROWS - 1), VAL_W'(ROWS - 1));
      mid_key = KEY_W'(column_model[ROWS / 2]);
      send_query(KIND_EQ, mid_key, 0, ROWS_POS);
      send_query(KIND_NE, mid_key, 0, ROWS_POS);
      send_query(KIND_LT, mid_key, 100, 900);
      send_query(KIND_LE, mid_key, 100, 900);
      send_query(KIND_GT, mid_key, 100, 900);
      send_query(KIND_GE, mid_key, 100, 900);
      send_query(KIND_NOT_NULL, mid_key, 0, ROWS_POS);
      send_query(KIND_EMPTY, mid_key, 0, ROWS_POS);
      send_query(KIND_EQ, 0, 0, ROWS_POS);
      send_query(KIND_EQ, 32'hFFFF_FFFF, 0, ROWS_POS);
      send_query(KIND_LT, 32'hFFFF_FFFF, 0, ROWS_POS);
      send_query(KIND_GE, KEY_W'(ROWS - 1), POS_W'(ROWS - 1), ROWS_POS);
      send_query(KIND_EQ, KEY_W'(ROWS - 1), 0, ROWS_POS);
      send_query(KIND_GT, KEY_W'(ROWS), 1000, ROWS_POS);
      // Range bounds past the end of the column saturate at the row count.
      send_query(KIND_GE, mid_key, 500, 11'd1500);
      send_query(KIND_EQ, mid_key, 11'd1200, 11'd2047);
      // A set start inside the range, with a different id at the range's first row.
      start = 300;
      while (int'(column_model[start]) != start) start++;
      send_query(KIND_EQ, KEY_W'(start), 10, ROWS_POS);
      send_query(KIND_LE, KEY_W'(start), POS_W'(start), POS_W'(start + 1));
      send_query(KIND_EQ, mid_key, ROWS_POS, ROWS_POS);
      send_query(KIND_NE, mid_key, 0, 0);
      send_query(KIND_LE, 5, 600, 200);
      send_query(KIND_LT, 5, 0, 1);
   endtask

   task automatic test_random_traffic();
      int pick;
      int first;
      int last;
      item_count = 0;
      while (item_count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
         pick = $urandom_range(0, 99);
         if (pick < 2) wait_for_results();
         if (pick < 70) begin
            random_query();
         end else if (pick < 93) begin
            first = $urandom_range(0, ROWS - 1);
            last  = first + $urandom_range(1, 16);
            // End the rewrite on a set start so the column stays sorted.
            while (last < ROWS && int'(column_model[last]) != last) last++;
            if (last > ROWS) last = ROWS;
            load_sets(first, last);
         end else begin
            send_load(IDX_W'($urandom_range(0, ROWS - 1)),
                      VAL_W'($urandom_range(0, ROWS - 1)));
         end
      end
      no_idle = 1'b0;
   endtask

   // Result side: checks each result it takes and draws a stall before the next.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         stall_count <= 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with none pending, result_lo",
                               32'(rsp_result_lo), 0);
            end else begin
               expected_next = expected_results.pop_front();
               if (rsp_result_lo !== expected_next.result_lo)
                  report_mismatch("result_lo", 32'(rsp_result_lo),
                                  32'(expected_next.result_lo));
               if (rsp_result_hi !== expected_next.result_hi)
                  report_mismatch("result_hi", 32'(rsp_result_hi),
                                  32'(expected_next.result_hi));
               if (rsp_complement !== expected_next.complement)
                  report_mismatch("complement", 32'(rsp_complement),
                                  32'(expected_next.complement));
            end
            next_stall = no_idle ? 0 : $urandom_range(0, 8);
         end else begin
            next_stall = (stall_count > 0) ? stall_count - 1 : 0;
         end
         stall_count <= next_stall;
         rsp_ready   <= (next_stall == 0);
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_column_fill();
      test_directed_queries();
      wait_for_results();
      test_random_traffic();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never returned", expected_results.size(), 0);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("timeout: results still pending %0d", expected_results.size());
      $display("status: fail");
      $finish;
   end

endmodule
